[rtl/core/kcs_pkg.sv]
package kcs_pkg;

	localparam int COMP_W   = 32;
	localparam int NUM_COMP = 4;
	localparam int VAL_W    = COMP_W * NUM_COMP;
	localparam int NUM_SLOTS = 3;

	// input operation codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// value slots of a key
	localparam logic [1:0] SLOT_IN    = 2'd0;
	localparam logic [1:0] SLOT_VALUE = 2'd1;
	localparam logic [1:0] SLOT_OUT   = 2'd2;

	// interpolation modes (code 3 behaves as linear)
	localparam logic [1:0] MODE_STEP   = 2'd0;
	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_CUBIC  = 2'd2;

	// register map
	localparam logic [2:0] ADDR_KEY_COUNT   = 3'd0;
	localparam logic [2:0] ADDR_INTERP_MODE = 3'd4;

	localparam logic [6:0] KEY_COUNT_RESET   = 7'd1;
	localparam logic [1:0] INTERP_MODE_RESET = MODE_LINEAR;

	// classified command handed from front to back
	typedef struct packed {
		logic              sample;
		logic [5:0]        key_index;
		logic [1:0]        value_slot;
		logic [31:0]       time_q16;
		logic [VAL_W-1:0]  comps;
	} cmd_t;

endpackage

[rtl/core/kcs_front.sv]
module kcs_front import kcs_pkg::*; #(
	parameter int MAX_KEYS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [5:0]  key_index,
	input  logic [1:0]  value_slot,
	input  logic [31:0] time_q16,
	input  logic [31:0] comp_x,
	input  logic [31:0] comp_y,
	input  logic [31:0] comp_z,
	input  logic [31:0] comp_w,
	output cmd_t        cmd,
	output logic        cmd_valid,
	input  logic        cmd_pop
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       take;
	logic       keep;
	cmd_t       cmd_in;

	// writes with a bad slot or key are dropped here
	always_comb begin
		cmd_in.sample     = (op == OP_SAMPLE);
		cmd_in.key_index  = key_index;
		cmd_in.value_slot = value_slot;
		cmd_in.time_q16   = time_q16;
		cmd_in.comps      = {comp_w, comp_z, comp_y, comp_x};
		keep = (op == OP_SAMPLE) ||
			((value_slot <= SLOT_OUT) && (32'(key_index) < 32'(MAX_KEYS)));
	end

	assign full      = (count_q == 2'd2);
	assign take      = push && !full;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (take && keep) wr_ptr_q <= !wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(take && keep) - 2'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (take && keep) fifo_q[wr_ptr_q] <= cmd_in;
	end

endmodule

[rtl/core/kcs_back.sv]
module kcs_back import kcs_pkg::*; #(
	parameter int MAX_KEYS  = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cmd_valid,
	output logic        cmd_pop,
	input  logic [6:0]  key_count,
	input  logic [1:0]  interp_mode,
	input  logic        pop,
	output logic        empty,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic [31:0] out_w,
	output logic [5:0]  segment_index,
	output logic        held_at_key
);

	localparam int KIW  = $clog2(MAX_KEYS);
	localparam int AW   = $clog2(NUM_SLOTS * MAX_KEYS);
	localparam int F    = FRAC_BITS;
	localparam int CW   = 33;
	localparam int PW   = 2 * CW;
	localparam int ACW  = PW + 2;
	localparam int CNW  = $clog2(F + 1);

	localparam logic signed [CW-1:0]  ONE_C   = CW'(1) <<< F;
	localparam logic signed [ACW-1:0] SAT_MAX = ACW'(64'sh7FFF_FFFF);
	localparam logic signed [ACW-1:0] SAT_MIN = -SAT_MAX - ACW'(1);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_T0    = 5'd1;
	localparam logic [4:0] ST_TN    = 5'd2;
	localparam logic [4:0] ST_CHK   = 5'd3;
	localparam logic [4:0] ST_SRCH  = 5'd4;
	localparam logic [4:0] ST_SRCHW = 5'd5;
	localparam logic [4:0] ST_DIVI  = 5'd6;
	localparam logic [4:0] ST_DIV   = 5'd7;
	localparam logic [4:0] ST_CO0   = 5'd8;
	localparam logic [4:0] ST_CO1   = 5'd9;
	localparam logic [4:0] ST_CO2   = 5'd10;
	localparam logic [4:0] ST_CO3   = 5'd11;
	localparam logic [4:0] ST_CO4   = 5'd12;
	localparam logic [4:0] ST_CO5   = 5'd13;
	localparam logic [4:0] ST_RD    = 5'd14;
	localparam logic [4:0] ST_RDL   = 5'd15;
	localparam logic [4:0] ST_MULI  = 5'd16;
	localparam logic [4:0] ST_MULA  = 5'd17;
	localparam logic [4:0] ST_SAT   = 5'd18;
	localparam logic [4:0] ST_OUT   = 5'd19;

	// key memories
	logic [31:0]    tmem [MAX_KEYS];
	logic [VAL_W-1:0] vmem [NUM_SLOTS * MAX_KEYS];
	logic signed [31:0] t_rd_q;
	logic [VAL_W-1:0]   v_rd_q;
	logic [KIW-1:0] t_raddr;
	logic [AW-1:0]  v_raddr;

	logic [4:0]  state_q, state_d;
	logic        out_valid_q;
	logic        load_out;

	logic signed [31:0] tc_q, t_lo_q, t_hi_q;
	logic [KIW-1:0] nm1_q, lower_q, upper_q, mid_q, seg_q, mid_c;
	logic           held_q;
	logic signed [CW-1:0] span_q, num_q;
	logic [CW-1:0]  rem_q, rem2;
	logic [F-1:0]   quo_q;
	logic [CNW-1:0] cnt_q;
	logic [F:0]     frac_q, fsq_q, p_frac;
	logic signed [CW-1:0] coef_q [NUM_COMP];
	logic [1:0]     nterm_q, term_q, comp_q;
	logic [VAL_W-1:0] vals_q [NUM_COMP];
	logic signed [ACW-1:0] acc_q, acc_sh;
	logic [31:0]    res_q [NUM_COMP];
	logic signed [CW-1:0] ma, mb;
	logic signed [PW-1:0] mul_p_q;
	logic signed [CW-1:0] frac_s, fsq_s, fcu_s;

	logic [KIW-1:0] widx;
	logic [AW-1:0]  waddr, base_c;
	logic [31:0]    n32;
	logic           wr_en;

	assign widx   = KIW'(32'(cmd.key_index));
	assign waddr  = AW'(NUM_SLOTS) * AW'(widx) + AW'(cmd.value_slot);
	assign base_c = AW'(NUM_SLOTS) * AW'(seg_q);
	assign mid_c  = lower_q + ((upper_q - lower_q) >> 1);
	assign p_frac = mul_p_q[F +: F+1];
	assign frac_s = CW'({1'b0, frac_q});
	assign fsq_s  = CW'({1'b0, fsq_q});
	assign fcu_s  = CW'({1'b0, p_frac});
	assign rem2   = {rem_q[CW-2:0], 1'b0};
	assign acc_sh = acc_q >>> F;
	assign n32    = (key_count == 7'd0) ? 32'd1 :
		((32'(key_count) > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : 32'(key_count));

	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign wr_en    = cmd_pop && !cmd.sample;
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || pop);
	assign empty    = !out_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tmem[widx]  <= cmd.time_q16;
			vmem[waddr] <= cmd.comps;
		end
		t_rd_q <= tmem[t_raddr];
		v_rd_q <= vmem[v_raddr];
		mul_p_q <= ma * mb;
	end

	always_comb begin
		state_d = state_q;
		t_raddr = '0;
		v_raddr = '0;
		ma = '0;
		mb = '0;
		case (state_q)
			ST_IDLE: if (cmd_valid && cmd.sample) state_d = ST_T0;
			ST_T0: state_d = ST_TN;
			ST_TN: begin
				t_raddr = nm1_q;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (nm1_q == '0 || tc_q <= t_lo_q || tc_q >= t_rd_q) state_d = ST_CO0;
				else state_d = ST_SRCH;
			end
			ST_SRCH: begin
				t_raddr = mid_c;
				if (upper_q - lower_q > KIW'(1)) state_d = ST_SRCHW;
				else state_d = ST_DIVI;
			end
			ST_SRCHW: state_d = ST_SRCH;
			ST_DIVI: begin
				if (span_q > 0 && num_q > 0 && num_q < span_q) state_d = ST_DIV;
				else state_d = ST_CO0;
			end
			ST_DIV: if (cnt_q == CNW'(1)) state_d = ST_CO0;
			ST_CO0: begin
				ma = frac_s;
				mb = frac_s;
				if (!held_q && interp_mode == MODE_CUBIC) state_d = ST_CO1;
				else state_d = ST_RD;
			end
			ST_CO1: begin
				ma = CW'({1'b0, p_frac});
				mb = frac_s;
				state_d = ST_CO2;
			end
			ST_CO2: state_d = ST_CO3;
			ST_CO3: begin
				ma = span_q;
				mb = coef_q[2];
				state_d = ST_CO4;
			end
			ST_CO4: begin
				ma = span_q;
				mb = coef_q[3];
				state_d = ST_CO5;
			end
			ST_CO5: state_d = ST_RD;
			ST_RD: begin
				case (term_q)
					2'd0: v_raddr = base_c + AW'(SLOT_VALUE);
					2'd1: v_raddr = base_c + AW'(NUM_SLOTS) + AW'(SLOT_VALUE);
					2'd2: v_raddr = base_c + AW'(SLOT_OUT);
					default: v_raddr = base_c + AW'(NUM_SLOTS) + AW'(SLOT_IN);
				endcase
				state_d = ST_RDL;
			end
			ST_RDL: state_d = (term_q == nterm_q) ? ST_MULI : ST_RD;
			ST_MULI: begin
				ma = CW'($signed(vals_q[term_q][COMP_W*comp_q +: COMP_W]));
				mb = coef_q[term_q];
				state_d = ST_MULA;
			end
			ST_MULA: state_d = (term_q == nterm_q) ? ST_SAT : ST_MULI;
			ST_SAT: state_d = (comp_q == 2'(NUM_COMP - 1)) ? ST_OUT : ST_MULI;
			ST_OUT: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				tc_q   <= $signed(cmd.time_q16);
				nm1_q  <= KIW'(n32 - 32'd1);
				held_q <= 1'b1;
				seg_q  <= '0;
				frac_q <= '0;
				span_q <= '0;
			end
			ST_TN: t_lo_q <= t_rd_q;
			ST_CHK: begin
				lower_q <= '0;
				upper_q <= nm1_q;
				t_hi_q  <= t_rd_q;
				if (!(nm1_q == '0 || tc_q <= t_lo_q) && tc_q >= t_rd_q) seg_q <= nm1_q;
			end
			ST_SRCH: begin
				mid_q <= mid_c;
				if (upper_q - lower_q <= KIW'(1)) begin
					seg_q  <= lower_q;
					held_q <= 1'b0;
					span_q <= CW'(t_hi_q) - CW'(t_lo_q);
					num_q  <= CW'(tc_q) - CW'(t_lo_q);
				end
			end
			ST_SRCHW: begin
				if (t_rd_q <= tc_q) begin
					lower_q <= mid_q;
					t_lo_q  <= t_rd_q;
				end else begin
					upper_q <= mid_q;
					t_hi_q  <= t_rd_q;
				end
			end
			ST_DIVI: begin
				rem_q <= num_q;
				quo_q <= '0;
				cnt_q <= CNW'(F);
				if (span_q > 0 && num_q > 0 && num_q >= span_q) frac_q <= (F+1)'(ONE_C);
			end
			ST_DIV: begin
				cnt_q <= cnt_q - CNW'(1);
				if (rem2 >= $unsigned(span_q)) begin
					rem_q <= rem2 - $unsigned(span_q);
					quo_q <= {quo_q[F-2:0], 1'b1};
					if (cnt_q == CNW'(1)) frac_q <= {1'b0, quo_q[F-2:0], 1'b1};
				end else begin
					rem_q <= rem2;
					quo_q <= {quo_q[F-2:0], 1'b0};
					if (cnt_q == CNW'(1)) frac_q <= {1'b0, quo_q[F-2:0], 1'b0};
				end
			end
			ST_CO0: begin
				term_q <= '0;
				if (held_q || interp_mode == MODE_STEP) begin
					coef_q[0] <= ONE_C;
					nterm_q   <= 2'd0;
				end else if (interp_mode != MODE_CUBIC) begin
					coef_q[0] <= ONE_C - frac_s;
					coef_q[1] <= frac_s;
					nterm_q   <= 2'd1;
				end
			end
			ST_CO1: fsq_q <= p_frac;
			ST_CO2: begin
				// hermite basis; the two tangent terms still need the span
				coef_q[0] <= fcu_s + fcu_s - (fsq_s + fsq_s + fsq_s) + ONE_C;
				coef_q[1] <= fsq_s + fsq_s + fsq_s - (fcu_s + fcu_s);
				coef_q[2] <= fcu_s - (fsq_s + fsq_s) + frac_s;
				coef_q[3] <= fcu_s - fsq_s;
			end
			ST_CO4: coef_q[2] <= mul_p_q[F +: CW];
			ST_CO5: begin
				coef_q[3] <= mul_p_q[F +: CW];
				nterm_q   <= 2'd3;
			end
			ST_RDL: begin
				vals_q[term_q] <= v_rd_q;
				if (term_q == nterm_q) begin
					term_q <= '0;
					comp_q <= '0;
					acc_q  <= '0;
				end else begin
					term_q <= term_q + 2'd1;
				end
			end
			ST_MULA: begin
				acc_q <= acc_q + ACW'(mul_p_q);
				if (term_q != nterm_q) term_q <= term_q + 2'd1;
			end
			ST_SAT: begin
				if (acc_sh > SAT_MAX) res_q[comp_q] <= 32'h7FFF_FFFF;
				else if (acc_sh < SAT_MIN) res_q[comp_q] <= 32'h8000_0000;
				else res_q[comp_q] <= acc_sh[31:0];
				acc_q  <= '0;
				term_q <= '0;
				comp_q <= comp_q + 2'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_x         <= res_q[0];
			out_y         <= res_q[1];
			out_z         <= res_q[2];
			out_w         <= res_q[3];
			segment_index <= 6'(32'(seg_q));
			held_at_key   <= held_q;
		end
	end

endmodule

[rtl/core/keyframe_curve_sampler.sv]
// keyframe curve sampler: holds one animation channel of up to MAX_KEYS keys, each a
// time plus in-tangent, value and out-tangent slots of four signed components, and
// samples it at query times. write items (op 0) load one key's time and one slot, with
// no result. sample items (op 1) give exactly one result: the back end reads the first
// and last key times and, for a time inside the key range, binary-searches the time
// memory and runs a restoring divide of one quotient bit per cycle for the fraction,
// then pushes every product through one shared 33x33 multiplier. key and query times
// are q16.16.
// a two-entry command queue lets the input side keep taking transfers while the back
// end works, and a result register holds the finished sample until it is popped.
// key_count (byte 0) and interp_mode (byte 4) must only change while the block is idle;
// key entries never written read back as garbage.
module keyframe_curve_sampler import kcs_pkg::*; #(
	parameter int MAX_KEYS  = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input queue side
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [5:0]  key_index,
	input  logic [1:0]  value_slot,
	input  logic [31:0] time_q16,
	input  logic [31:0] comp_x,
	input  logic [31:0] comp_y,
	input  logic [31:0] comp_z,
	input  logic [31:0] comp_w,
	// result register side
	output logic        empty,
	input  logic        pop,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic [31:0] out_w,
	output logic [5:0]  segment_index,
	output logic        held_at_key,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [6:0] key_count_q;
	logic [1:0] interp_mode_q;
	logic       cfg_wr;
	cmd_t       cmd;
	logic       cmd_valid;
	logic       cmd_pop;

	// register file: zero-wait writes, reads return the stored value
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q   <= KEY_COUNT_RESET;
			interp_mode_q <= INTERP_MODE_RESET;
		end else if (cfg_wr) begin
			if (paddr == ADDR_KEY_COUNT) key_count_q <= pwdata[6:0];
			if (paddr == ADDR_INTERP_MODE) interp_mode_q <= pwdata[1:0];
		end
	end

	always_comb begin
		case (paddr)
			ADDR_KEY_COUNT:   prdata = 32'(key_count_q);
			ADDR_INTERP_MODE: prdata = 32'(interp_mode_q);
			default:          prdata = '0;
		endcase
	end

	// front: takes each transfer, drops bad writes, queues the rest
	kcs_front #(
		.MAX_KEYS(MAX_KEYS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.key_index  (key_index),
		.value_slot (value_slot),
		.time_q16   (time_q16),
		.comp_x     (comp_x),
		.comp_y     (comp_y),
		.comp_z     (comp_z),
		.comp_w     (comp_w),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop)
	);

	// back: key memories, search, divide, blend and the result register
	kcs_back #(
		.MAX_KEYS  (MAX_KEYS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cmd_valid     (cmd_valid),
		.cmd_pop       (cmd_pop),
		.key_count     (key_count_q),
		.interp_mode   (interp_mode_q),
		.pop           (pop),
		.empty         (empty),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_z         (out_z),
		.out_w         (out_w),
		.segment_index (segment_index),
		.held_at_key   (held_at_key)
	);

endmodule
